[hdl/kef_pkg.sv]
// Package for the Kruskal edge filter: shared constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package kef_pkg;

  // Default number of vertices the union-find store can hold.
  localparam int MAX_VERTICES_DEF = 1024;

  // Vertex count in effect after reset, before clamping to the store size.
  localparam int VC_RESET = 1024;

  // Set ranks are small; they saturate at RANK_MAX.
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(15);

  // Depth of the queues between the front, the back and the result side.
  localparam int QUEUE_DEPTH = 2;

endpackage : kef_pkg

`default_nettype wire

[hdl/kef_queue.sv]
// Small first-in first-out queue built from registers.
// Depends on kef_pkg for the default depth.
`default_nettype none

module kef_queue import kef_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic      [W-1:0] data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and fill count updates; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + NW'(1);
      2'b01:   cnt_d = cnt_q - NW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage holds payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : kef_queue

`default_nettype wire

[hdl/kef_front.sv]
// Front part of the edge filter: accepts edges, flags bad endpoints and
// queues them for the back part. Depends on kef_pkg and kef_queue.
`default_nettype none

module kef_front import kef_pkg::*; #(
  parameter int VW = 10,
  parameter int CW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [VW-1:0] vertex_a_i,
  input  wire logic [VW-1:0] vertex_b_i,
  input  wire logic [CW-1:0] vertex_count_i,
  input  wire logic          clearing_i,
  input  wire logic          item_pop_i,
  output logic               item_valid_o,
  output logic      [VW-1:0] item_a_o,
  output logic      [VW-1:0] item_b_o,
  output logic               item_bad_o
);

  logic          bad;
  logic          q_full, q_empty;
  logic [2*VW:0] q_wdata, q_rdata;

  // An endpoint at or above the vertex count makes the edge bad.
  assign bad = ({1'b0, vertex_a_i} >= vertex_count_i) |
               ({1'b0, vertex_b_i} >= vertex_count_i);

  assign q_wdata = {bad, vertex_b_i, vertex_a_i};

  // No edge is taken while the store is being cleared.
  assign full_o = q_full | clearing_i;

  kef_queue #(
    .W     (2 * VW + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_edge_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i & ~clearing_i),
    .data_i  (q_wdata),
    .pop_i   (item_pop_i),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign item_valid_o = ~q_empty;
  assign item_a_o     = q_rdata[VW-1:0];
  assign item_b_o     = q_rdata[2*VW-1:VW];
  assign item_bad_o   = q_rdata[2*VW];

endmodule : kef_front

`default_nettype wire

[hdl/kef_back.sv]
// Back part of the edge filter: union-find engine with parent and rank
// memories, root walks with path halving, join by rank and clearing sweep.
// Depends on kef_pkg.
`default_nettype none

module kef_back import kef_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int VW           = 10,
  parameter int CW           = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] vertex_count_i,
  input  wire logic          item_valid_i,
  input  wire logic [VW-1:0] item_a_i,
  input  wire logic [VW-1:0] item_b_i,
  input  wire logic          item_bad_i,
  output logic               item_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output logic      [VW-1:0] res_a_o,
  output logic      [VW-1:0] res_b_o,
  output logic               res_acc_o,
  output logic               res_bad_o,
  output logic      [VW-1:0] res_total_o,
  output logic               res_done_o,
  output logic               clearing_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHK    = 8'b0000_0100,
    S_HALVE  = 8'b0000_1000,
    S_RANK_A = 8'b0001_0000,
    S_JOIN   = 8'b0010_0000,
    S_DONE   = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_e;

  localparam logic [VW-1:0] LastIdx = VW'(MAX_VERTICES - 1);

  state_e            state_q, state_d;
  logic              phase_q, phase_d;
  logic [VW-1:0]     x_q, x_d;
  logic [VW-1:0]     root_a_q, root_a_d;
  logic [VW-1:0]     a_q, a_d;
  logic [VW-1:0]     b_q, b_d;
  logic              bad_q, bad_d;
  logic              acc_q, acc_d;
  logic [RANK_W-1:0] rank_a_q, rank_a_d;
  logic [VW-1:0]     total_q, total_d;
  logic [VW-1:0]     clr_idx_q, clr_idx_d;

  // Memory ports.
  logic [VW-1:0]     parent_mem [MAX_VERTICES];
  logic [RANK_W-1:0] rank_mem   [MAX_VERTICES];
  logic              p_we, r_we;
  logic [VW-1:0]     p_wa, p_wd, p_ra, p_rd_q;
  logic [VW-1:0]     r_wa, r_ra;
  logic [RANK_W-1:0] r_wd, r_rd_q;

  // Sequencer: root walks, rank reads and join as needed; one result each.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    x_d        = x_q;
    root_a_d   = root_a_q;
    a_d        = a_q;
    b_d        = b_q;
    bad_d      = bad_q;
    acc_d      = acc_q;
    rank_a_d   = rank_a_q;
    total_d    = total_q;
    clr_idx_d  = clr_idx_q;
    p_we       = 1'b0;
    p_wa       = x_q;
    p_wd       = x_q;
    p_ra       = x_q;
    r_we       = 1'b0;
    r_wa       = root_a_q;
    r_wd       = '0;
    r_ra       = root_a_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // Each entry becomes its own root with rank zero.
        p_we      = 1'b1;
        p_wa      = clr_idx_q;
        p_wd      = clr_idx_q;
        r_we      = 1'b1;
        r_wa      = clr_idx_q;
        clr_idx_d = clr_idx_q + VW'(1);
        if (clr_idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        p_ra = item_a_i;
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          a_d        = item_a_i;
          b_d        = item_b_i;
          bad_d      = item_bad_i;
          acc_d      = 1'b0;
          x_d        = item_a_i;
          phase_d    = 1'b0;
          state_d    = item_bad_i ? S_DONE : S_CHK;
        end
      end
      S_CHK: begin
        if (p_rd_q == x_q) begin
          if (!phase_q) begin
            // Root of the first endpoint found; start on the second.
            root_a_d = x_q;
            x_d      = b_q;
            p_ra     = b_q;
            phase_d  = 1'b1;
          end else if (root_a_q == x_q) begin
            state_d = S_DONE;
          end else begin
            r_ra    = root_a_q;
            state_d = S_RANK_A;
          end
        end else begin
          // Fetch the grandparent for the halving step.
          p_ra    = p_rd_q;
          state_d = S_HALVE;
        end
      end
      S_HALVE: begin
        p_we    = 1'b1;
        p_wa    = x_q;
        p_wd    = p_rd_q;
        x_d     = p_rd_q;
        p_ra    = p_rd_q;
        state_d = S_CHK;
      end
      S_RANK_A: begin
        rank_a_d = r_rd_q;
        r_ra     = x_q;
        state_d  = S_JOIN;
      end
      S_JOIN: begin
        // The lower ranked root goes under the other; ties go under root a.
        acc_d = 1'b1;
        if (total_q != '1) begin
          total_d = total_q + VW'(1);
        end
        p_we = 1'b1;
        if (rank_a_q < r_rd_q) begin
          p_wa = root_a_q;
          p_wd = x_q;
        end else begin
          p_wa = x_q;
          p_wd = root_a_q;
          if (rank_a_q == r_rd_q) begin
            r_we = 1'b1;
            r_wa = root_a_q;
            r_wd = (rank_a_q == RANK_MAX) ? rank_a_q : rank_a_q + RANK_W'(1);
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // A vertex count write restarts the sets.
    if (cfg_we_i) begin
      state_d   = S_CLEAR;
      clr_idx_d = '0;
      total_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
      total_q   <= '0;
      phase_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      total_q   <= total_d;
      phase_q   <= phase_d;
    end
  end

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    root_a_q <= root_a_d;
    a_q      <= a_d;
    b_q      <= b_d;
    bad_q    <= bad_d;
    acc_q    <= acc_d;
    rank_a_q <= rank_a_d;
  end

  // Parent link memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_wa] <= p_wd;
    end
    p_rd_q <= parent_mem[p_ra];
  end

  // Set rank memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rank_mem[r_wa] <= r_wd;
    end
    r_rd_q <= rank_mem[r_ra];
  end

  assign res_a_o     = a_q;
  assign res_b_o     = b_q;
  assign res_acc_o   = acc_q;
  assign res_bad_o   = bad_q;
  assign res_total_o = total_q;
  assign res_done_o  = ({1'b0, total_q} == (vertex_count_i - CW'(1)));
  assign clearing_o  = (state_q == S_CLEAR);

`ifndef SYNTHESIS
  // Two sets are only joined when their roots differ.
  a_join_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JOIN) |-> (root_a_q != x_q))
    else $error("join of a set with itself");

  // The tree edge count never passes the vertex count minus one.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, total_q} <= (vertex_count_i - CW'(1))))
    else $error("tree edge count beyond vertex count minus one");

  // Each join adds exactly one tree edge.
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JOIN && !cfg_we_i && total_q != '1) |=>
      (total_q == $past(total_q) + VW'(1)))
    else $error("tree edge count did not advance on a join");

  // The parent memory is written only by the sweep, halving or a join.
  a_parent_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we |-> (state_q == S_CLEAR || state_q == S_HALVE || state_q == S_JOIN))
    else $error("parent link written outside sweep, halving or join");
`endif

endmodule : kef_back

`default_nettype wire

[hdl/kruskal_edge_filter_top.sv]
// Top level of the Kruskal edge filter: vertex count register, front part,
// back part and result queue. Depends on kef_pkg, kef_queue, kef_front, kef_back.
`default_nettype none

// Kruskal edge filter. Edges, sorted by weight, enter through push/full;
// one result per edge leaves through empty/pop, in order. An edge with an
// endpoint at or above the vertex count is flagged and skips the root
// walks. An edge that joins two sets takes longer than one that closes a
// cycle, and both take longer with each path halving step in the two root
// walks: each halving step waits for the grandparent read after the parent
// read, and the join needs two rank memory reads before its writes. After
// reset, and after every write of the vertex count, a clearing pass
// rewrites every entry of the store while full stays high. Written vertex
// counts are clamped to the range 2 to MAX_VERTICES.
module kruskal_edge_filter_top import kef_pkg::*; #(
  parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int VW           = $clog2(MAX_VERTICES),
  localparam int CW           = VW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [VW-1:0] vertex_a_i,
  input  wire logic [VW-1:0] vertex_b_i,
  output logic               empty,
  input  wire logic          pop,
  output logic      [VW-1:0] edge_a_o,
  output logic      [VW-1:0] edge_b_o,
  output logic               accepted_o,
  output logic               bad_vertex_o,
  output logic      [VW-1:0] tree_edges_o,
  output logic               tree_done_o,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i
);

  localparam int RstCount = (VC_RESET > MAX_VERTICES) ? MAX_VERTICES : VC_RESET;
  localparam int RW       = 3 * VW + 3;

  logic [CW-1:0] vcount_q, vcount_d;
  logic          clearing;
  logic          item_valid, item_pop, item_bad;
  logic [VW-1:0] item_a, item_b;
  logic          res_full, res_push;
  logic [VW-1:0] res_a, res_b, res_total;
  logic          res_acc, res_bad, res_done;
  logic [RW-1:0] res_wdata, res_rdata;

  // Written vertex counts are clamped into the store's range.
  always_comb begin
    if (cfg_wdata_i < CW'(2)) begin
      vcount_d = CW'(2);
    end else if (cfg_wdata_i > CW'(MAX_VERTICES)) begin
      vcount_d = CW'(MAX_VERTICES);
    end else begin
      vcount_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CW'(RstCount);
    end else if (cfg_we_i) begin
      vcount_q <= vcount_d;
    end
  end

  kef_front #(
    .VW (VW),
    .CW (CW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .vertex_count_i (vcount_q),
    .clearing_i     (clearing),
    .item_pop_i     (item_pop),
    .item_valid_o   (item_valid),
    .item_a_o       (item_a),
    .item_b_o       (item_b),
    .item_bad_o     (item_bad)
  );

  kef_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW),
    .CW           (CW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .vertex_count_i (vcount_q),
    .item_valid_i   (item_valid),
    .item_a_i       (item_a),
    .item_b_i       (item_b),
    .item_bad_i     (item_bad),
    .item_pop_o     (item_pop),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_a_o        (res_a),
    .res_b_o        (res_b),
    .res_acc_o      (res_acc),
    .res_bad_o      (res_bad),
    .res_total_o    (res_total),
    .res_done_o     (res_done),
    .clearing_o     (clearing)
  );

  // Finished results wait here so the engine can take the next edge.
  assign res_wdata = {res_done, res_total, res_bad, res_acc, res_b, res_a};

  kef_queue #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign edge_a_o     = res_rdata[VW-1:0];
  assign edge_b_o     = res_rdata[2*VW-1:VW];
  assign accepted_o   = res_rdata[2*VW];
  assign bad_vertex_o = res_rdata[2*VW+1];
  assign tree_edges_o = res_rdata[3*VW+1:2*VW+2];
  assign tree_done_o  = res_rdata[3*VW+2];

endmodule : kruskal_edge_filter_top

`default_nettype wire

[tb/edge_result_checker.sv]
// Checker for the Kruskal edge filter: watches the edge, result and vertex count
// channels, predicts every result and compares it. Depends on kef_pkg.
`default_nettype none

module edge_result_checker import kef_pkg::*; #(
  parameter  int MAX_VERTICES = MAX_VERTICES_DEF,
  localparam int VW           = $clog2(MAX_VERTICES),
  localparam int CW           = VW + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  input  wire logic          full,
  input  wire logic [VW-1:0] vertex_a_i,
  input  wire logic [VW-1:0] vertex_b_i,
  input  wire logic          empty,
  input  wire logic          pop,
  input  wire logic [VW-1:0] edge_a_i,
  input  wire logic [VW-1:0] edge_b_i,
  input  wire logic          accepted_i,
  input  wire logic          bad_vertex_i,
  input  wire logic [VW-1:0] tree_edges_i,
  input  wire logic          tree_done_i,
  input  wire logic          cfg_we_i,
  input  wire logic [CW-1:0] cfg_wdata_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted result, field by field.
  typedef struct packed {
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic          acc;
    logic          bad;
    logic [VW-1:0] edges;
    logic          done;
  } edge_outcome_t;

  // Private copy of the union-find store and the vertex count.
  logic [VW-1:0]     link_of [MAX_VERTICES];
  logic [RANK_W-1:0] rank_of [MAX_VERTICES];
  logic [VW-1:0]     tree_total;
  logic [CW-1:0]     vertex_limit;
  edge_outcome_t     expected_outcomes [$];
  int unsigned       fail_count = 0;

  // Every vertex becomes its own set and the tree is emptied.
  function automatic void clear_sets();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      link_of[i] = VW'(i);
      rank_of[i] = '0;
    end
    tree_total = '0;
  endfunction

  // Written counts outside 2 to MAX_VERTICES are pulled to the nearest bound.
  function automatic logic [CW-1:0] clamp_limit(int unsigned w);
    if (w < 2) return CW'(2);
    if (w > MAX_VERTICES) return CW'(MAX_VERTICES);
    return CW'(w);
  endfunction

  // Walk to the root, pointing each visited link at its grandparent.
  function automatic logic [VW-1:0] root_of(logic [VW-1:0] v);
    logic [VW-1:0] x;
    int            steps;
    x = v;
    steps = 0;
    while (link_of[x] != x && steps < MAX_VERTICES) begin
      link_of[x] = link_of[link_of[x]];
      x = link_of[x];
      steps++;
    end
    return x;
  endfunction

  // Outcome of one edge, updating the store as the block should.
  function automatic edge_outcome_t predict_edge_outcome(logic [VW-1:0] a, logic [VW-1:0] b);
    edge_outcome_t o;
    logic [VW-1:0] ra;
    logic [VW-1:0] rb;
    o = '0;
    o.a = a;
    o.b = b;
    if ({1'b0, a} >= vertex_limit || {1'b0, b} >= vertex_limit) begin
      o.bad = 1'b1;
    end else begin
      ra = root_of(a);
      rb = root_of(b);
      if (ra != rb) begin
        // Union by rank; equal ranks hang the second root under the first.
        if (rank_of[ra] < rank_of[rb]) begin
          link_of[ra] = rb;
        end else if (rank_of[ra] > rank_of[rb]) begin
          link_of[rb] = ra;
        end else begin
          link_of[rb] = ra;
          if (rank_of[ra] != RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
        end
        o.acc = 1'b1;
        if (tree_total != '1) tree_total = tree_total + 1'b1;
      end
    end
    o.edges = tree_total;
    o.done  = ({1'b0, tree_total} == vertex_limit - 1'b1);
    return o;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Follow every transfer on the three channels at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    edge_outcome_t want;
    if (!rst_ni) begin
      vertex_limit = clamp_limit(VC_RESET);
      clear_sets();
      expected_outcomes.delete();
    end else begin
      if (cfg_we_i) begin
        vertex_limit = clamp_limit(cfg_wdata_i);
        clear_sets();
      end
      if (push && !full) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 predict_edge_outcome(vertex_a_i, vertex_b_i));
      end
      if (pop && !empty) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result transfer with none expected: edge %0d-%0d", $time,
                   edge_a_i, edge_b_i);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          compare_field("edge_a", want.a, edge_a_i);
          compare_field("edge_b", want.b, edge_b_i);
          compare_field("accepted", want.acc, accepted_i);
          compare_field("bad_vertex", want.bad, bad_vertex_i);
          compare_field("tree_edges", want.edges, tree_edges_i);
          compare_field("tree_done", want.done, tree_done_i);
        end
      end
    end
    pending_o    <= expected_outcomes.size();
    fail_count_o <= fail_count;
  end

endmodule : edge_result_checker

`default_nettype wire

[tb/testbench.sv]
// Top of the Kruskal edge filter testbench: clock, reset, edge stimulus with
// random idling, and the verdict. Depends on kef_pkg, the block and edge_result_checker.
`default_nettype none

module testbench import kef_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = $clog2(MAX_VERTICES_DEF);
  localparam int CW = VW + 1;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          push = 1'b0;
  logic          full;
  logic [VW-1:0] vertex_a = '0;
  logic [VW-1:0] vertex_b = '0;
  logic          empty;
  logic          pop = 1'b0;
  logic [VW-1:0] edge_a;
  logic [VW-1:0] edge_b;
  logic          accepted;
  logic          bad_vertex;
  logic [VW-1:0] tree_edges;
  logic          tree_done;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  int unsigned   pending;
  int unsigned   fail_count;

  // Chance of an idle burst is 1 in the given odds; zero means no idling.
  int unsigned   gap_odds = 0;
  int unsigned   pop_odds = 0;
  int unsigned   stall_left = 0;
  int unsigned   perm [MAX_VERTICES_DEF];

  kruskal_edge_filter_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .vertex_a_i   (vertex_a),
    .vertex_b_i   (vertex_b),
    .empty        (empty),
    .pop          (pop),
    .edge_a_o     (edge_a),
    .edge_b_o     (edge_b),
    .accepted_o   (accepted),
    .bad_vertex_o (bad_vertex),
    .tree_edges_o (tree_edges),
    .tree_done_o  (tree_done),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  edge_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .vertex_a_i   (vertex_a),
    .vertex_b_i   (vertex_b),
    .empty        (empty),
    .pop          (pop),
    .edge_a_i     (edge_a),
    .edge_b_i     (edge_b),
    .accepted_i   (accepted),
    .bad_vertex_i (bad_vertex),
    .tree_edges_i (tree_edges),
    .tree_done_i  (tree_done),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Result side: pop stays high except during random stall bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if (pop_odds != 0 && $urandom_range(1, pop_odds) == 1) begin
      stall_left <= $urandom_range(1, 17) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Offer one edge, possibly after an idle burst, and hold it until the transfer.
  task automatic send_edge(input int unsigned a, input int unsigned b);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    push     <= 1'b1;
    vertex_a <= VW'(a);
    vertex_b <= VW'(b);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has been transferred.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CW'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One setting of the vertex count, then mostly edges that grow a spanning
  // tree over a shuffled vertex order, mixed with cycle-closing and bad edges.
  task automatic random_phase(input int unsigned w, input int n_edges, input bit hold_midway);
    int unsigned vc;
    int unsigned grown;
    int unsigned j;
    int unsigned t;
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    write_vertex_count(w);
    vc = (w < 2) ? 2 : (w > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : w;
    for (int i = 0; i < vc; i++) perm[i] = i;
    for (int i = vc - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    grown = 1;
    for (int n = 0; n < n_edges; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        a = $urandom_range(0, 2 ** VW - 1);
        b = $urandom_range(0, 2 ** VW - 1);
      end else if (pick < 14 && vc < 2 ** VW) begin
        a = $urandom_range(vc, 2 ** VW - 1);
        b = $urandom_range(0, vc - 1);
        if ($urandom_range(0, 1) == 1) begin
          t = a;
          a = b;
          b = t;
        end
      end else if (pick < 70 && grown < vc) begin
        a = perm[grown];
        b = perm[$urandom_range(0, grown - 1)];
        if ($urandom_range(0, 1) == 1) begin
          t = a;
          a = b;
          b = t;
        end
        grown++;
      end else begin
        a = $urandom_range(0, vc - 1);
        b = $urandom_range(0, vc - 1);
      end
      send_edge(a, b);
      if (hold_midway && n == n_edges / 2) settle();
    end
  endtask

  initial begin : stimulus
    int unsigned w;
    int          n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    gap_odds = 4;
    pop_odds = 4;

    // Reset count: far endpoints, a repeated pair, a self loop, a closed cycle.
    send_edge(0, 1023);
    send_edge(1023, 0);
    send_edge(5, 5);
    send_edge(1, 2);
    send_edge(2, 3);
    send_edge(1, 3);
    send_edge(512, 511);
    send_edge(10'h155, 10'h2AA);
    send_edge(10'h2AA, 10'h155);

    // Smallest tree: a zero write is raised to two vertices.
    write_vertex_count(0);
    send_edge(0, 1);
    send_edge(1, 0);
    send_edge(0, 2);
    send_edge(1023, 1);
    send_edge(1, 1);

    // Oversized writes fall back to the full store; a write of one is raised to two.
    write_vertex_count(2047);
    send_edge(1023, 1022);
    write_vertex_count(1025);
    send_edge(0, 1);
    write_vertex_count(1);
    send_edge(1, 1);
    send_edge(0, 1);

    // Three vertices: fill the tree, then edges after completion.
    write_vertex_count(3);
    send_edge(0, 3);
    send_edge(2, 1);
    send_edge(0, 2);
    send_edge(1, 0);

    // Random part; the last phase runs without idling on either side.
    for (int ph = 0; ph < 10; ph++) begin
      gap_odds = (ph == 9) ? 0 : $urandom_range(0, 2) * 3;
      pop_odds = (ph == 9) ? 0 : $urandom_range(0, 2) * 3;
      if (ph == 4) begin
        w = $urandom_range(513, 700);
        n = 720;
      end else if (ph % 3 == 2) begin
        w = $urandom_range(0, 2 ** CW - 1);
        n = 60;
      end else begin
        w = $urandom_range(2, 40);
        n = 60;
      end
      random_phase(w, n, ph == 4);
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
